/* src/wave_equation_stencil_step_core_defines.svh */
// Assertion macros used by the checker file of the wave stencil core.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef WAVE_EQUATION_STENCIL_STEP_CORE_DEFINES_SVH
`define WAVE_EQUATION_STENCIL_STEP_CORE_DEFINES_SVH

// condition on this edge implies consequence on this edge
`define WES_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition on this edge implies consequence on the next edge
`define WES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/wes_pkg.sv */
// Shared types, widths and register codes of the wave stencil core.
// No dependencies; all RTL files but wes_line_mem refer to it by scoped names.
package wes_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int COORD_BITS      = 8;
	localparam int GAIN_BITS       = 16;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int GRID_WIDTH_DEF  = 256;
	localparam int GRID_HEIGHT_DEF = 256;

	// d = m*u + N+E+S+W - 2p gets four bits of headroom (three would suffice)
	localparam int DIFF_BITS   = SAMPLE_BITS + 4;
	localparam int GL_BITS     = 2 * GAIN_BITS;
	localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 2 * COORD_BITS + 7) / 8) * 8;

	localparam logic [GAIN_BITS-1:0] LOSS_RESET   = 16'd4089;
	localparam logic [GAIN_BITS-1:0] EDGE_RESET   = 16'd61688;
	localparam logic [GAIN_BITS-1:0] CORNER_RESET = 16'd58263;
	localparam logic [GAIN_BITS:0]   UNITY_GAIN   = 17'h10000;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LOSS_FACTOR = 2'd0,
		REG_EDGE_GAIN   = 2'd1,
		REG_CORNER_GAIN = 2'd2
	} reg_idx_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// stencil neighbourhood around the center cell
	typedef struct packed {
		sample_t north;
		sample_t east;
		sample_t south;
		sample_t west;
		sample_t center;
		sample_t prev;
		logic    valid;
	} win_t;

	// operands handed to the multiply stages
	typedef struct packed {
		logic                         pass;
		sample_t                      cur;
		sample_t                      prev;
		logic signed [DIFF_BITS-1:0]  diff;
		logic [1:0]                   m;
		logic [GAIN_BITS:0]           gain;
		logic [GL_BITS-1:0]           gl;
		logic [COORD_BITS-1:0]        col;
		logic [COORD_BITS-1:0]        row;
		logic                         last;
	} op_t;

	typedef struct packed {
		sample_t               value;
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic                  last;
		logic                  sat;
	} res_t;

endpackage

/* src/wes_line_mem.sv */
// Single-port line memory, read-before-write, registered read data.
// Generic; used by wes_window as a fixed-depth delay line.
module wes_line_mem #(
	parameter int DEPTH = 255,
	parameter int WIDTH = 49
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			rdata      <= mem[addr];
			mem[addr]  <= wdata;
		end
	end

endmodule

/* src/wes_window.sv */
// Raster window: line memory delay lines plus the window registers.
// Depends on wes_pkg and wes_line_mem.
module wes_window #(
	parameter int GRID_WIDTH = wes_pkg::GRID_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              flush,
	input  wes_pkg::sample_t  cur_in,
	input  wes_pkg::sample_t  prev_in,
	output wes_pkg::win_t     win
);

	localparam int SB    = wes_pkg::SAMPLE_BITS;
	localparam int DEPTH = GRID_WIDTH - 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int FILL  = GRID_WIDTH + 2;
	localparam int FW    = $clog2(FILL + 1);
	localparam int MW    = 3 * SB + 1;

	wes_pkg::sample_t s_x_q, s_p_q, sd_q, c_x_q, c_p_q, w_q;
	logic             s_v_q, c_v_q;
	logic [AW-1:0]    ptr_q;
	logic [FW-1:0]    fill_q;
	logic [MW-1:0]    wdata, rdata;

	wes_pkg::sample_t rd_x, rd_p, rd_n;
	logic             rd_v;

	// upper part: newest cell one line back; lower part: center cell, read back as the north tap
	assign wdata = {s_v_q, s_p_q, s_x_q, c_x_q};
	assign {rd_v, rd_p, rd_x, rd_n} = rdata;

	wes_line_mem #(
		.DEPTH (DEPTH),
		.WIDTH (MW)
	) u_mem (
		.clk   (clk),
		.en    (accept),
		.addr  (ptr_q),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_v_q  <= 1'b0;
			c_v_q  <= 1'b0;
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			s_v_q <= !flush;
			c_v_q <= rd_v;
			ptr_q <= (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
			if (fill_q != FW'(FILL)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_x_q <= flush ? '0 : cur_in;
			s_p_q <= flush ? '0 : prev_in;
			sd_q  <= s_x_q;
			c_x_q <= rd_x;
			c_p_q <= rd_p;
			w_q   <= c_x_q;
		end
	end

	always_comb begin
		win.north  = rd_n;
		win.east   = rd_x;
		win.south  = sd_q;
		win.west   = w_q;
		win.center = c_x_q;
		win.prev   = c_p_q;
		// center slot only meaningful once enough words went through
		win.valid  = c_v_q && (fill_q == FW'(FILL));
	end

endmodule

/* src/wes_update.sv */
// Multiply, round and saturate stages plus the output register.
// Depends on wes_pkg.
module wes_update (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_valid,
	input  wes_pkg::op_t    op,
	output logic            op_ready,
	output logic            res_valid,
	input  logic            res_ready,
	output wes_pkg::res_t   res
);

	localparam int SB  = wes_pkg::SAMPLE_BITS;
	localparam int AB  = wes_pkg::DIFF_BITS + wes_pkg::GAIN_BITS + 2;
	localparam int BB  = wes_pkg::GL_BITS + 1 + SB;
	localparam int TW  = SB + 40;
	localparam int RB  = TW - 33;
	localparam logic signed [TW-1:0] HALF = TW'(1) <<< 32;
	localparam logic signed [RB-1:0] HI   = RB'((1 << (SB - 1)) - 1);
	localparam logic signed [RB-1:0] LO   = -HI - RB'(1);

	logic                   s3_v_q, out_v_q, out_rdy, s3_rdy;
	logic signed [AB-1:0]   a_mul, a_s3;
	logic signed [BB-1:0]   b_mul, b_s3;
	logic                   pass_s3;
	wes_pkg::sample_t       u_s3;
	logic [1:0]             m_s3;
	logic [wes_pkg::COORD_BITS-1:0] col_s3, row_s3;
	logic                   last_s3;
	logic signed [TW-1:0]   ta, tb, tot;
	logic signed [RB-1:0]   r;
	wes_pkg::res_t          res_d, res_q;

	assign out_rdy   = !out_v_q || res_ready;
	assign s3_rdy    = !s3_v_q || out_rdy;
	assign op_ready  = s3_rdy;
	assign res_valid = out_v_q;
	assign res       = res_q;

	always_comb begin
		a_mul = op.diff * $signed({1'b0, op.gain});
		b_mul = $signed({1'b0, op.gl}) * op.prev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s3_rdy) begin
				s3_v_q <= op_valid;
			end
			if (out_rdy) begin
				out_v_q <= s3_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_rdy && op_valid) begin
			a_s3    <= a_mul;
			b_s3    <= b_mul;
			pass_s3 <= op.pass;
			u_s3    <= op.cur;
			m_s3    <= op.m;
			col_s3  <= op.col;
			row_s3  <= op.row;
			last_s3 <= op.last;
		end
	end

	// x*g = 2^16*g*d + 2*m*(g*LF)*p, rounded by 2^-33 with ties up
	always_comb begin
		ta = {{(TW - AB - 16){a_s3[AB-1]}}, a_s3, 16'b0};
		case (m_s3)
			2'd1:    tb = {{(TW - BB - 1){b_s3[BB-1]}}, b_s3, 1'b0};
			2'd2:    tb = {{(TW - BB - 2){b_s3[BB-1]}}, b_s3, 2'b0};
			default: tb = '0;
		endcase
		tot = ta + tb + HALF;
		r   = tot[TW-1:33];

		res_d.col  = col_s3;
		res_d.row  = row_s3;
		res_d.last = last_s3;
		if (pass_s3) begin
			res_d.value = u_s3;
			res_d.sat   = 1'b0;
		end else if (r > HI) begin
			res_d.value = HI[SB-1:0];
			res_d.sat   = 1'b1;
		end else if (r < LO) begin
			res_d.value = LO[SB-1:0];
			res_d.sat   = 1'b1;
		end else begin
			res_d.value = r[SB-1:0];
			res_d.sat   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && s3_v_q) begin
			res_q <= res_d;
		end
	end

endmodule

/* src/wave_equation_stencil_step_core.sv */
// Top level of the 2-D wave stencil step: config regs, operand stage, output stream.
// Depends on wes_pkg, wes_window, wes_update. Throughput: one word per clock while m_tready stays high.
// A cell's result leaves once the word GRID_WIDTH+1 words later is accepted and the cell has
// passed the window, operand, multiply and round/saturate stages.
// Reset (arst_n, async): control cleared, config regs to their reset values, line memory
// left as is; the first GRID_WIDTH+1 words after reset give no result (fill count).
module wave_equation_stencil_step_core #(
	parameter int GRID_WIDTH  = wes_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = wes_pkg::GRID_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [wes_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [wes_pkg::GAIN_BITS-1:0]       cfg_data,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [wes_pkg::IN_DATA_BITS-1:0]    s_tdata,   // current_value, previous_value
	input  logic                                s_tuser,   // kind (1 = flush bubble)
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [wes_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // next_value, column, row
	output logic                                m_tlast,   // frame_last
	output logic                                m_tuser    // saturated
);

	localparam int SB = wes_pkg::SAMPLE_BITS;
	localparam int DB = wes_pkg::DIFF_BITS;
	localparam int CW = $clog2(GRID_WIDTH);
	localparam int RW = $clog2(GRID_HEIGHT);

	// config registers and the gain*loss products derived from them
	logic [wes_pkg::GAIN_BITS-1:0] loss_q, edge_q, corner_q;
	logic [wes_pkg::GL_BITS-1:0]   gle_q, glc_q;

	// handshake / stage control
	logic win_v_q, s2_v_q, s2_rdy, upd_rdy, in_accept, win_take;

	// output coordinate counters, advanced once per emitted cell
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	wes_pkg::win_t    win;
	wes_pkg::op_t     op_d, op_s2;
	wes_pkg::res_t    res;
	wes_pkg::sample_t cur_in, prev_in;

	logic       on_left, on_right, on_top, on_bottom, near_col, near_row;
	logic [1:0] m;
	logic signed [DB-1:0] mu, nesw, p2;

	assign cur_in  = s_tdata[SB-1:0];
	assign prev_in = s_tdata[2*SB-1:SB];

	// --- config ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_q   <= wes_pkg::LOSS_RESET;
			edge_q   <= wes_pkg::EDGE_RESET;
			corner_q <= wes_pkg::CORNER_RESET;
		end else if (cfg_we) begin
			case (wes_pkg::reg_idx_t'(cfg_index))
				wes_pkg::REG_LOSS_FACTOR: loss_q   <= cfg_data;
				wes_pkg::REG_EDGE_GAIN:   edge_q   <= cfg_data;
				wes_pkg::REG_CORNER_GAIN: corner_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// registered from the config regs; user must make config changes only while idle (unenforced)
	always_ff @(posedge clk) begin
		gle_q <= edge_q * loss_q;
		glc_q <= corner_q * loss_q;
	end

	// --- handshake: each stage takes a word when empty or when it drains ---
	assign s2_rdy    = !s2_v_q || upd_rdy;
	assign s_tready  = !win_v_q || s2_rdy;
	assign in_accept = s_tvalid && s_tready;
	assign win_take  = win_v_q && s2_rdy;

	wes_window #(
		.GRID_WIDTH (GRID_WIDTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_accept),
		.flush   (s_tuser),
		.cur_in  (cur_in),
		.prev_in (prev_in),
		.win     (win)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_v_q <= 1'b0;
			s2_v_q  <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (in_accept) begin
				win_v_q <= 1'b1;
			end else if (s2_rdy) begin
				win_v_q <= 1'b0;
			end

			if (win_take) begin
				s2_v_q <= win.valid;
			end else if (upd_rdy) begin
				s2_v_q <= 1'b0;
			end

			if (win_take && win.valid) begin
				if (col_q == CW'(GRID_WIDTH - 1)) begin
					col_q <= '0;
					row_q <= (row_q == RW'(GRID_HEIGHT - 1)) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// --- operand stage: border class, loss count m, stencil sum ---
	always_comb begin
		on_left   = (col_q == '0);
		on_right  = (col_q == CW'(GRID_WIDTH - 1));
		on_top    = (row_q == '0);
		on_bottom = (row_q == RW'(GRID_HEIGHT - 1));
		near_col  = (col_q == CW'(1)) || (col_q == CW'(GRID_WIDTH - 2));
		near_row  = (row_q == RW'(1)) || (row_q == RW'(GRID_HEIGHT - 2));
		m         = {1'b0, near_row} + {1'b0, near_col};

		nesw = {{(DB - SB){win.north[SB-1]}}, win.north}
		     + {{(DB - SB){win.east[SB-1]}},  win.east}
		     + {{(DB - SB){win.south[SB-1]}}, win.south}
		     + {{(DB - SB){win.west[SB-1]}},  win.west};
		p2   = {{(DB - SB - 1){win.prev[SB-1]}}, win.prev, 1'b0};

		case (m)
			2'd1: begin
				mu        = {{(DB - SB){win.center[SB-1]}}, win.center};
				op_d.gain = {1'b0, edge_q};
				op_d.gl   = gle_q;
			end
			2'd2: begin
				mu        = {{(DB - SB - 1){win.center[SB-1]}}, win.center, 1'b0};
				op_d.gain = {1'b0, corner_q};
				op_d.gl   = glc_q;
			end
			default: begin
				mu        = '0;
				op_d.gain = wes_pkg::UNITY_GAIN;
				op_d.gl   = '0;
			end
		endcase

		op_d.pass = on_left || on_right || on_top || on_bottom;
		op_d.cur  = win.center;
		op_d.prev = win.prev;
		op_d.diff = mu + nesw - p2;
		op_d.m    = m;
		op_d.col  = wes_pkg::COORD_BITS'(col_q);
		op_d.row  = wes_pkg::COORD_BITS'(row_q);
		op_d.last = on_right && on_bottom;
	end

	always_ff @(posedge clk) begin
		if (win_take) begin
			op_s2 <= op_d;
		end
	end

	wes_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (s2_v_q),
		.op        (op_s2),
		.op_ready  (upd_rdy),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = wes_pkg::OUT_DATA_BITS'({res.row, res.col, res.value});
	assign m_tlast = res.last;
	assign m_tuser = res.sat;

endmodule

/* src/wes_checker.sv */
// Port-level checker for the wave stencil core, bound to the top level.
// Depends on wes_pkg and the assertion macro header.
`include "wave_equation_stencil_step_core_defines.svh"

module wes_checker #(
	parameter int GRID_WIDTH  = wes_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = wes_pkg::GRID_HEIGHT_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [wes_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	input logic                                m_tlast,
	input logic                                m_tuser
);

	// stalled result word holds
	`WES_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result word changed while stalled")

	// frame end flag only on the bottom-right cell
	`WES_ASSERT_NOW(a_last_pos, m_tvalid && m_tlast, (m_tdata[23:16] == 8'(GRID_WIDTH - 1)) && (m_tdata[31:24] == 8'(GRID_HEIGHT - 1)), "frame end flag off the last cell")

	// coordinates stay on the grid
	`WES_ASSERT_NOW(a_coord_range, m_tvalid, (m_tdata[23:16] <= 8'(GRID_WIDTH - 1)) && (m_tdata[31:24] <= 8'(GRID_HEIGHT - 1)), "result coordinate off the grid")

	// left and top border cells pass through and never clip
	`WES_ASSERT_NOW(a_border_clean, m_tvalid && ((m_tdata[23:16] == 8'd0) || (m_tdata[31:24] == 8'd0)), !m_tuser, "border cell flagged saturated")

	// a clipped value sits at a rail
	`WES_ASSERT_NOW(a_sat_rail, m_tvalid && m_tuser, (m_tdata[15:0] == 16'h7fff) || (m_tdata[15:0] == 16'h8000), "saturated value not at a rail")

endmodule

bind wave_equation_stencil_step_core wes_checker #(
	.GRID_WIDTH  (GRID_WIDTH),
	.GRID_HEIGHT (GRID_HEIGHT)
) u_wes_checker (.*);
